// ===== hw/rtl/prmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package prmt_pkg;

    // Tree shape
    localparam int TREE_LEVELS = 4;
    localparam int LEAF_COUNT  = 3 ** TREE_LEVELS;
    localparam int NODE_COUNT  = (3 * LEAF_COUNT - 1) / 2;
    localparam int FIRST_LEAF  = (LEAF_COUNT - 1) / 2;
    // One row per inner node, holding that node's three children
    localparam int ROW_COUNT   = FIRST_LEAF;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int ROW_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    // Divide by three as multiply by reciprocal, exact below 2**DIV3_SHIFT
    localparam int DIV3_SHIFT  = 11;
    localparam int DIV3_MUL    = (2 ** DIV3_SHIFT + 1) / 3;
    localparam int DIV3_MUL_W  = $clog2(DIV3_MUL + 1);

    // Field widths
    localparam int INDEX_W     = 7;
    localparam int STATUS_W    = 2;

    typedef enum logic {
        CMD_REVEAL = 1'b0,
        CMD_FORGET = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_REVEALED     = 2'd1,
        STATUS_NOT_REVEALED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               command;
        logic [INDEX_W-1:0] leaf_index;
        logic               leaf_value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                root_known;
        logic                root_value;
    } t_out_item;

    // Known and value bits of the three children of one node
    typedef struct packed {
        logic [2:0] known;
        logic [2:0] value;
    } t_row;

endpackage

`default_nettype wire

// ===== hw/rtl/partial_recursive_majority_tree.sv =====
// Each item climbs from its leaf's parent row to the root; ST_READ reads each level and
// ST_EVAL evaluates it. An out-of-range leaf index goes straight to ST_DONE, and a repeated
// reveal or forget of an unrevealed leaf stops at its first evaluation. One item at a time:
// the next follows ST_DONE, which stalls on an untransferred result; each level costs one read
// and one write-back of the child row memory through the shared majority and parent-index unit.
// Reset (synchronous, active low) clears the row valid bits at once: every node reads unknown.
`timescale 1ns / 1ps
`default_nettype none

module partial_recursive_majority_tree (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  prmt_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output prmt_pkg::t_out_item  o_out_data
);
    import prmt_pkg::*;

    // Child row memory and its valid bits
    t_row                 r_mem [ROW_COUNT];
    logic [ROW_COUNT-1:0] r_row_vld;
    t_row                 r_rd_data;
    logic                 r_rd_vld;

    t_state               r_state, n_state;
    logic [ROW_W-1:0]     r_row, n_row;
    logic [1:0]           r_pos, n_pos;
    logic                 r_first, n_first;
    logic                 r_cmd;
    logic                 r_leaf_value;
    logic                 r_node_k, n_node_k;
    logic                 r_node_v, n_node_v;
    logic                 r_root_k, n_root_k;
    logic                 r_root_v, n_root_v;
    t_status              r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out_data, n_out_data;

    logic                 in_xfer;
    logic                 in_range;
    logic                 wr_en;
    logic [NODE_W-1:0]    pu_node;
    logic [NODE_W-1:0]    pu_pm1;
    logic [NODE_W+DIV3_MUL_W-1:0] pu_prod;
    logic [ROW_W-1:0]     pu_row;
    logic [NODE_W-1:0]    pu_row_ext;
    logic [NODE_W-1:0]    pu_rem;
    logic [1:0]           pu_pos;
    t_row                 row_in;
    t_row                 row_mod;
    logic                 leaf_known;
    logic                 bad_cmd;
    logic                 ab, ac, bc;
    logic                 maj_k, maj_v;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign in_range = (int'(i_in_data.leaf_index) < LEAF_COUNT);

    // Shared parent unit: row of the parent and slot within that row
    always_comb begin
        if (r_state == ST_IDLE) begin
            pu_node = NODE_W'(FIRST_LEAF) + NODE_W'(i_in_data.leaf_index);
        end else begin
            pu_node = NODE_W'(r_row);
        end
        pu_pm1     = pu_node - NODE_W'(1);
        pu_prod    = (NODE_W+DIV3_MUL_W)'(pu_pm1) * (NODE_W+DIV3_MUL_W)'(DIV3_MUL);
        pu_row     = pu_prod[DIV3_SHIFT +: ROW_W];
        pu_row_ext = NODE_W'(pu_row);
        pu_rem     = pu_pm1 - (pu_row_ext << 1) - pu_row_ext;
        pu_pos     = pu_rem[1:0];
    end

    // Row update and majority of the updated row
    always_comb begin
        row_in     = r_rd_vld ? r_rd_data : '0;
        leaf_known = row_in.known[r_pos];
        bad_cmd    = r_first && ((r_cmd == CMD_REVEAL) == leaf_known);
        row_mod    = row_in;
        if (r_first) begin
            row_mod.known[r_pos] = (r_cmd == CMD_REVEAL);
            if (r_cmd == CMD_REVEAL) begin
                row_mod.value[r_pos] = r_leaf_value;
            end
        end else begin
            row_mod.known[r_pos] = r_node_k;
            row_mod.value[r_pos] = r_node_v;
        end
        ab    = row_mod.known[0] && row_mod.known[1] && (row_mod.value[0] == row_mod.value[1]);
        ac    = row_mod.known[0] && row_mod.known[2] && (row_mod.value[0] == row_mod.value[2]);
        bc    = row_mod.known[1] && row_mod.known[2] && (row_mod.value[1] == row_mod.value[2]);
        maj_k = ab || ac || bc;
        maj_v = (ab || ac) ? row_mod.value[0] : row_mod.value[1];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = in_range ? ST_READ : ST_DONE;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (bad_cmd || (r_row == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and datapath next values
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE) && i_rst_n;
        n_row       = r_row;
        n_pos       = r_pos;
        n_first     = r_first;
        n_node_k    = r_node_k;
        n_node_v    = r_node_v;
        n_root_k    = r_root_k;
        n_root_v    = r_root_v;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        wr_en       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_row    = pu_row;
                    n_pos    = pu_pos;
                    n_first  = 1'b1;
                    n_status = STATUS_OK;
                end
            end
            ST_READ: begin
            end
            ST_EVAL: begin
                if (bad_cmd) begin
                    n_status = (r_cmd == CMD_REVEAL) ? STATUS_REVEALED : STATUS_NOT_REVEALED;
                end else begin
                    wr_en    = 1'b1;
                    n_first  = 1'b0;
                    n_node_k = maj_k;
                    n_node_v = maj_v;
                    if (r_row == '0) begin
                        n_root_k = maj_k;
                        n_root_v = maj_v;
                    end else begin
                        n_row = pu_row;
                        n_pos = pu_pos;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out_data.status     = r_status;
                    n_out_data.root_known = r_root_k;
                    n_out_data.root_value = r_root_k && r_root_v;
                end
            end
            default: begin
            end
        endcase
    end

    // Row memory: registered read at the current row, write-back on evaluation
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_row];
        r_rd_vld  <= r_row_vld[r_row];
        if (wr_en) begin
            r_mem[r_row] <= row_mod;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_vld   <= '0;
            r_root_k    <= 1'b0;
            r_root_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root_k    <= n_root_k;
            r_root_v    <= n_root_v;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_row_vld[r_row] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_pos      <= n_pos;
        r_first    <= n_first;
        r_node_k   <= n_node_k;
        r_node_v   <= n_node_v;
        r_status   <= n_status;
        r_out_data <= n_out_data;
        if (in_xfer) begin
            r_cmd        <= i_in_data.command;
            r_leaf_value <= i_in_data.leaf_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== hw/rtl/prmt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module prmt_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input prmt_pkg::t_in_item   i_in_data,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input prmt_pkg::t_out_item  o_out_data
);
    import prmt_pkg::*;

    // Hold a waiting result until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped before transfer");

    // Drop ready right after an input transfer: one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after input transfer");

    // Status is one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == STATUS_OK ||
                         o_out_data.status == STATUS_REVEALED ||
                         o_out_data.status == STATUS_NOT_REVEALED))
        else $error("undefined status code");

    // Root value only shown when the root is known
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.root_value |-> o_out_data.root_known)
        else $error("root value set while root unknown");

endmodule

bind partial_recursive_majority_tree prmt_checker u_prmt_checker (.*);

`default_nettype wire
